/* sv/hse_pkg.sv */
`default_nettype none

package hse_pkg;

  // Store depth and derived widths.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int DATA_W   = 32;

  // One request on the input channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  // One request on the output channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     run_end;
    logic                     overflow;
  } result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_SETUP,
    S_SIFT,
    S_CMP,
    S_XREAD,
    S_XSWAP,
    S_ORD,
    S_OCAP,
    S_OWAIT
  } state_t;

  // Outcome of one sift-down comparison step.
  typedef struct packed {
    logic                     move;
    logic [ADDR_W-1:0]        top;
    logic signed [DATA_W-1:0] top_value;
  } pick_t;

  // Heap child positions, wide enough to compare against the heap limit.
  function automatic logic [IDX_W-1:0] left_child(input logic [ADDR_W-1:0] node);
    return {1'b0, node, 1'b1};
  endfunction

  function automatic logic [IDX_W-1:0] right_child(input logic [ADDR_W-1:0] node);
    return left_child(node) + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

/* sv/hse_ram.sv */
`default_nettype none

module hse_ram #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* sv/hse_pick.sv */
`default_nettype none

module hse_pick import hse_pkg::*; (
  input  logic [ADDR_W-1:0]        node,
  input  logic [CNT_W-1:0]         limit,
  input  logic signed [DATA_W-1:0] cur,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output pick_t                    pick
);

  logic [IDX_W-1:0] lc;
  logic [IDX_W-1:0] rc;
  logic [IDX_W-1:0] lim;

  assign lc  = left_child(node);
  assign rc  = right_child(node);
  assign lim = IDX_W'(limit);

  // Choose the largest of the held value and the children inside the heap.
  // Ties keep the earlier candidate, so a value only moves when strictly smaller.
  always_comb begin
    pick.move      = 1'b0;
    pick.top       = node;
    pick.top_value = cur;
    if (lc < lim && cur < left_value) begin
      pick.move      = 1'b1;
      pick.top       = lc[ADDR_W-1:0];
      pick.top_value = left_value;
    end
    if (rc < lim && pick.top_value < right_value) begin
      pick.move      = 1'b1;
      pick.top       = rc[ADDR_W-1:0];
      pick.top_value = right_value;
    end
  end

endmodule

`default_nettype wire

/* sv/heap_sort_engine.sv */
// Channel | Direction | Handshake                 | Payload
// item    | in        | item_valid / item_stall   | item_t   (value, last)
// result  | out       | result_valid / result_stall | result_t (sorted_value, run_end, overflow)
//
// Loading takes one item per cycle while the store is collecting a set.
// After the last item, each sift-down level reads both children, then compares and
// writes back. Each result is then read through one read port and held while the
// output stalls.
// Reset clears the sequencer, the element count and the overflow mark; no clearing pass.
// Input is stalled from the last item until the final result has been taken.
`default_nettype none

module heap_sort_engine import hse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic                     ovf, ovf_next;
  logic [CNT_W-1:0]         size, size_next;
  logic [CNT_W-1:0]         k, k_next;
  logic [ADDR_W-1:0]        node, node_next;
  logic [CNT_W-1:0]         limit, limit_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic                     building, building_next;
  logic [CNT_W-1:0]         idx, idx_next;
  result_t                  res, res_next;
  logic                     res_valid, res_valid_next;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [ADDR_W-1:0]        rd_addr_a;
  logic [ADDR_W-1:0]        rd_addr_b;
  logic [DATA_W-1:0]        rd_data_a;
  logic [DATA_W-1:0]        rd_data_b;
  logic [CNT_W-1:0]         n_total;
  logic [IDX_W-1:0]         lc_full;
  logic [IDX_W-1:0]         rc_full;
  pick_t                    pick;

  assign lc_full = left_child(node);
  assign rc_full = right_child(node);

  // Element store.
  hse_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  // Sift-down comparison.
  hse_pick u_pick (
    .node        (node),
    .limit       (limit),
    .cur         (cur),
    .left_value  (rd_data_a),
    .right_value (rd_data_b),
    .pick        (pick)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ovf       <= ovf_next;
      res_valid <= res_valid_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    size     <= size_next;
    k        <= k_next;
    node     <= node_next;
    limit    <= limit_next;
    cur      <= cur_next;
    building <= building_next;
    idx      <= idx_next;
    res      <= res_next;
  end

  // Sequencer: load, heap build, root extraction, read-out.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ovf_next       = ovf;
    size_next      = size;
    k_next         = k;
    node_next      = node;
    limit_next     = limit;
    cur_next       = cur;
    building_next  = building;
    idx_next       = idx;
    res_next       = res;
    res_valid_next = res_valid;
    wr_en          = 1'b0;
    wr_addr        = node;
    wr_data        = cur;
    rd_addr_a      = node;
    rd_addr_b      = node;
    item_stall     = 1'b1;
    n_total        = cnt;
    unique case (state)
      S_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (cnt < CNT_W'(CAPACITY)) begin
            wr_en   = 1'b1;
            wr_addr = cnt[ADDR_W-1:0];
            wr_data = item.value;
            n_total = cnt + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          cnt_next = n_total;
          if (item.last) begin
            cnt_next  = '0;
            size_next = n_total;
            if (n_total > CNT_W'(1)) begin
              building_next = 1'b1;
              k_next        = n_total >> 1;
              node_next     = ADDR_W'((n_total >> 1) - CNT_W'(1));
              limit_next    = n_total;
              state_next    = S_FETCH;
            end else begin
              idx_next   = '0;
              state_next = S_ORD;
            end
          end
        end
      end
      S_FETCH: begin
        rd_addr_a  = node;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cur_next   = $signed(rd_data_a);
        rd_addr_a  = lc_full[ADDR_W-1:0];
        rd_addr_b  = rc_full[ADDR_W-1:0];
        state_next = S_CMP;
      end
      S_SIFT: begin
        rd_addr_a  = lc_full[ADDR_W-1:0];
        rd_addr_b  = rc_full[ADDR_W-1:0];
        state_next = S_CMP;
      end
      S_CMP: begin
        wr_en   = 1'b1;
        wr_addr = node;
        if (pick.move) begin
          // Child moves up into the hole; the held value travels down.
          wr_data    = pick.top_value;
          node_next  = pick.top;
          state_next = S_SIFT;
        end else begin
          wr_data = cur;
          if (building) begin
            if (k > CNT_W'(1)) begin
              k_next     = k - CNT_W'(1);
              node_next  = ADDR_W'(k - CNT_W'(2));
              state_next = S_FETCH;
            end else begin
              building_next = 1'b0;
              k_next        = size;
              state_next    = S_XREAD;
            end
          end else begin
            k_next = k - CNT_W'(1);
            if (k > CNT_W'(2)) begin
              state_next = S_XREAD;
            end else begin
              idx_next   = '0;
              state_next = S_ORD;
            end
          end
        end
      end
      S_XREAD: begin
        rd_addr_a  = '0;
        rd_addr_b  = ADDR_W'(k - CNT_W'(1));
        state_next = S_XSWAP;
      end
      S_XSWAP: begin
        // Root goes to the end of the heap; the old end value sifts from the root.
        wr_en      = 1'b1;
        wr_addr    = ADDR_W'(k - CNT_W'(1));
        wr_data    = rd_data_a;
        cur_next   = $signed(rd_data_b);
        node_next  = '0;
        limit_next = k - CNT_W'(1);
        state_next = S_SIFT;
      end
      S_ORD: begin
        rd_addr_a  = idx[ADDR_W-1:0];
        state_next = S_OCAP;
      end
      S_OCAP: begin
        res_next.sorted_value = $signed(rd_data_a);
        res_next.run_end      = (idx + CNT_W'(1)) == size;
        res_next.overflow     = ovf;
        res_valid_next        = 1'b1;
        idx_next              = idx + CNT_W'(1);
        state_next            = S_OWAIT;
      end
      S_OWAIT: begin
        rd_addr_a = idx[ADDR_W-1:0];
        if (!result_stall) begin
          res_valid_next = 1'b0;
          if (res.run_end) begin
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            state_next = S_OCAP;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  assign result_valid = res_valid;
  assign result       = res;

endmodule

`default_nettype wire

/* sv/hse_checker.sv */
`default_nettype none

module hse_checker import hse_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or was withdrawn");

  // Input is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open while a result is pending");

  // After the final result of a run the block is ready for a new set.
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.run_end |=> !result_valid && !item_stall)
    else $error("block not ready after final result");

  // Loading continues without a pause until the last item.
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !item.last |=> !item_stall && !result_valid)
    else $error("load phase interrupted before last item");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);

`default_nettype wire
